/* rtl/core/mrfp_pkg.sv */
// ----------------------------------------------------------------------------
// mrfp_pkg
// Shared types and constants of the motor reply frame parser.
// ----------------------------------------------------------------------------
package mrfp_pkg;

  localparam logic [7:0] POSITION_OPCODE = 8'h36;
  localparam logic [7:0] FRAME_END_MARK  = 8'h6B;
  localparam logic [7:0] MAX_DIRECTION   = 8'h01;

  // Byte positions inside a frame
  localparam int IDX_ADDRESS     = 0;
  localparam int IDX_COMMAND     = 1;
  localparam int IDX_STATUS      = 2;
  localparam int IDX_COUNT_FIRST = 3;
  localparam int IDX_COUNT_LAST  = 6;

  typedef struct packed {
    logic        frame_kind;
    logic [7:0]  reply_command;
    logic [7:0]  reply_status;
    logic        direction_negative;
    logic [31:0] position_count;
    logic [31:0] sequence_number;
  } result_t;

endpackage

/* rtl/core/mrfp_deframer.sv */
// ----------------------------------------------------------------------------
// mrfp_deframer
// Frame state, byte capture, frame checks and sequence counters.
// ----------------------------------------------------------------------------
module mrfp_deframer #(
  parameter int POSITION_FRAME_BYTES = 8,
  parameter int CONTROL_FRAME_BYTES  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           device_address,
  output logic                 res_valid,
  output mrfp_pkg::result_t    res
);

  localparam int CW = $clog2(POSITION_FRAME_BYTES + 1);

  logic [CW-1:0] byte_count;
  logic [CW-1:0] expected_length;
  logic [7:0]    first_byte;
  logic [7:0]    opcode_byte;
  logic [7:0]    third_byte;
  logic [31:0]   count_shift;
  logic [31:0]   control_sequence;
  logic [31:0]   pos_seq_count;

  logic          is_start;
  logic          take;
  logic [CW-1:0] count_inc;
  logic          done;
  logic          good;
  logic          is_pos;
  logic          pos_ok;

  always_comb begin
    is_start  = (rx_byte == device_address);
    take      = fire && ((byte_count != '0) || is_start);
    count_inc = byte_count + CW'(1);
    done      = take && (expected_length != '0) && (count_inc >= expected_length);
    good      = done && (first_byte == device_address) &&
                (rx_byte == mrfp_pkg::FRAME_END_MARK);
    is_pos    = (opcode_byte == mrfp_pkg::POSITION_OPCODE);
    pos_ok    = (third_byte <= mrfp_pkg::MAX_DIRECTION);
    res_valid = good && (!is_pos || pos_ok);

    res = '0;
    if (is_pos) begin
      res.frame_kind         = 1'b1;
      res.direction_negative = third_byte[0];
      res.position_count     = count_shift;
      res.sequence_number    = pos_seq_count + 32'd1;
    end else begin
      res.frame_kind      = 1'b0;
      res.reply_command   = opcode_byte;
      res.reply_status    = third_byte;
      res.sequence_number = control_sequence + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (byte_count == CW'(mrfp_pkg::IDX_ADDRESS)) begin
        first_byte <= rx_byte;
      end
      if (byte_count == CW'(mrfp_pkg::IDX_COMMAND)) begin
        opcode_byte <= rx_byte;
      end
      if (byte_count == CW'(mrfp_pkg::IDX_STATUS)) begin
        third_byte <= rx_byte;
      end
      if (byte_count >= CW'(mrfp_pkg::IDX_COUNT_FIRST) &&
          byte_count <= CW'(mrfp_pkg::IDX_COUNT_LAST)) begin
        count_shift <= {count_shift[23:0], rx_byte};
      end
      if (done && is_start) begin
        first_byte <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      expected_length   <= '0;
      control_sequence  <= '0;
      pos_seq_count     <= '0;
    end else if (take) begin
      if (done) begin
        byte_count      <= is_start ? CW'(1) : '0;
        expected_length <= '0;
        if (res_valid && is_pos) begin
          pos_seq_count <= pos_seq_count + 32'd1;
        end
        if (res_valid && !is_pos) begin
          control_sequence <= control_sequence + 32'd1;
        end
      end else begin
        byte_count <= count_inc;
        if (count_inc == CW'(2)) begin
          expected_length <= (rx_byte == mrfp_pkg::POSITION_OPCODE) ?
                             CW'(POSITION_FRAME_BYTES) : CW'(CONTROL_FRAME_BYTES);
        end
      end
    end
  end

endmodule

/* rtl/core/mrfp_out_reg.sv */
// ----------------------------------------------------------------------------
// mrfp_out_reg
// Result register holding one reply until the receiver takes it.
// ----------------------------------------------------------------------------
module mrfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  mrfp_pkg::result_t load_data,
  input  logic              out_ready,
  output logic              out_valid,
  output mrfp_pkg::result_t data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      data <= load_data;
    end
  end

endmodule

/* rtl/core/motor_reply_frame_parser.sv */
// ----------------------------------------------------------------------------
// motor_reply_frame_parser
// Deframes motor replies from a stream of received serial bytes.
// ----------------------------------------------------------------------------
// Input channel: rx_byte with in_valid/in_ready, one byte per item.
// Output channel: one reply per good frame with out_valid/out_ready; control
// replies carry command and status, position replies carry direction and
// count; each kind has its own wrapping sequence number.
// Config: cfg_wr_en/cfg_wr_data set the device address, taken at once.
// Path: a byte is registered in the input register; the reply from the
// frame's last byte is loaded into the result register as that byte leaves
// the input register, and out_valid rises with that load.
// Throughput: one byte per cycle; the input register and the result register
// each move whenever the result register is empty or being taken.
// Stall: while a reply waits, one more byte is held in the input register,
// then in_ready drops.
// Reset: frame state and both sequence counters clear, address becomes 1,
// no reply pending.
// ----------------------------------------------------------------------------
module motor_reply_frame_parser #(
  parameter int POSITION_FRAME_BYTES = 8,
  parameter int CONTROL_FRAME_BYTES  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_kind,
  output logic [7:0]  reply_command,
  output logic [7:0]  reply_status,
  output logic        direction_negative,
  output logic [31:0] position_count,
  output logic [31:0] sequence_number
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_advance;
  logic              s1_fire;
  logic [7:0]        device_address;
  logic              res_valid;
  mrfp_pkg::result_t res;
  mrfp_pkg::result_t out_data;

  assign s1_advance = !out_valid || out_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'h01;
    end else if (cfg_wr_en) begin
      device_address <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  mrfp_deframer #(
    .POSITION_FRAME_BYTES (POSITION_FRAME_BYTES),
    .CONTROL_FRAME_BYTES  (CONTROL_FRAME_BYTES)
  ) u_deframer (
    .clk            (clk),
    .rst            (rst),
    .fire           (s1_fire),
    .rx_byte        (s1_byte),
    .device_address (device_address),
    .res_valid      (res_valid),
    .res            (res)
  );

  mrfp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_advance),
    .load_valid (s1_fire && res_valid),
    .load_data  (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .data       (out_data)
  );

  assign frame_kind         = out_data.frame_kind;
  assign reply_command      = out_data.reply_command;
  assign reply_status       = out_data.reply_status;
  assign direction_negative = out_data.direction_negative;
  assign position_count     = out_data.position_count;
  assign sequence_number    = out_data.sequence_number;

`ifndef SYNTHESIS
  a_pos_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind |-> reply_command == 8'h00 && reply_status == 8'h00)
    else $error("position reply carries control fields");

  a_ctrl_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_kind |-> position_count == 32'h0 && !direction_negative)
    else $error("control reply carries position fields");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire))
    else $error("reply appeared without a processed byte");
`endif

endmodule
